// File: src/ssd_fmt_pkg.sv
// types, mode codes and byte constants for the seven-segment display formatter
// no dependencies; imported by seven_segment_display_formatter_core
`default_nettype none

package ssd_fmt_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned ValueW = 16;
  localparam int unsigned DecW   = 14;
  localparam int unsigned QuotW  = 11;
  localparam int unsigned RecipW = 13;

  localparam logic [ModeW-1:0] ModeCustom = 3'd0;
  localparam logic [ModeW-1:0] ModeHexDig = 3'd1;
  localparam logic [ModeW-1:0] ModeHex16  = 3'd2;
  localparam logic [ModeW-1:0] ModeDec16  = 3'd3;
  localparam logic [ModeW-1:0] ModeHex8   = 3'd4;
  localparam logic [ModeW-1:0] ModeErr    = 3'd5;

  localparam logic [7:0]        CmdRaw     = 8'b0111_1000;
  localparam logic [7:0]        CmdHex     = 8'b0101_1000;
  localparam logic [7:0]        DpBit      = 8'h80;
  localparam logic [ValueW-1:0] DecLimit   = 16'd9999;
  localparam logic [7:0]        SegR       = 8'b1110_1010;
  localparam logic [3:0]        DigitE     = 4'hE;
  localparam logic [RecipW-1:0] RecipTen   = 13'd6554;

  typedef enum logic [2:0] {
    K_RAW,
    K_HEXDIG,
    K_HEX16,
    K_DEC16,
    K_HEX8,
    K_ERR
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMD  = 3'b010,
    S_DATA = 3'b100
  } state_e;

  function automatic logic [7:0] hex_data(input logic [3:0] digit, input logic dp);
    hex_data = {~dp, 3'b000, digit};
  endfunction

endpackage

`default_nettype wire

// File: src/seven_segment_display_formatter_core.sv
// seven-segment display formatter: one request becomes command/data byte writes
// depends on ssd_fmt_pkg
//
// channel   direction  signals
// request   in         start_i, busy_o, mode_i, addr_i, value_i, dp_on_i, line_i
// result    out        strobe_o, port_byte_o, is_command_o, last_o
//
// a transaction is taken when start_i is high, busy_o low and mode_i a used mode code
// each write is a command byte then a data byte, and a request makes 1, 2, 3 or 4
// writes; unused mode codes are not taken and make no writes
// decimal digits come from one shared divide-by-ten unit, one digit per write
// rst_ni clears the sequencer to idle; results are one-cycle strobes, never stalled
`default_nettype none

module seven_segment_display_formatter_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  output logic                              busy_o,
  input  wire  [ssd_fmt_pkg::ModeW-1:0]     mode_i,
  input  wire  [ssd_fmt_pkg::AddrW-1:0]     addr_i,
  input  wire  [ssd_fmt_pkg::ValueW-1:0]    value_i,
  input  wire                               dp_on_i,
  input  wire                               line_i,
  output logic                              strobe_o,
  output logic [7:0]                        port_byte_o,
  output logic                              is_command_o,
  output logic                              last_o
);

  import ssd_fmt_pkg::*;

  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic                load;
  logic [1:0]          wr_q, wr_d;
  logic [1:0]          wr_last;
  logic [AddrW-1:0]    addr_q;
  logic                line_q;
  logic                dp_q;
  logic [ValueW-1:0]   w_q, w_d;
  logic [DecW+RecipW-1:0] prod;
  logic [QuotW-1:0]    quot;
  logic [DecW-1:0]     rem_full;
  logic [3:0]          rem;
  logic [AddrW-1:0]    pos;
  logic                raw;
  logic [7:0]          data;

  // shared divide-by-ten unit
  assign prod     = w_q[DecW-1:0] * RecipTen;
  assign quot     = prod[DecW+RecipW-1 -: QuotW];
  assign rem_full = w_q[DecW-1:0] - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign rem      = rem_full[3:0];

  always_comb begin
    load   = 1'b1;
    kind_d = K_RAW;
    unique case (mode_i)
      ModeCustom: kind_d = K_RAW;
      ModeHexDig: kind_d = K_HEXDIG;
      ModeHex16:  kind_d = K_HEX16;
      ModeDec16:  kind_d = (value_i > DecLimit) ? K_ERR : K_DEC16;
      ModeHex8:   kind_d = K_HEX8;
      ModeErr:    kind_d = K_ERR;
      default:    load   = 1'b0;
    endcase
  end

  always_comb begin
    pos     = addr_q;
    raw     = 1'b0;
    data    = hex_data(w_q[3:0], 1'b0);
    wr_last = 2'd0;
    unique case (kind_q)
      K_RAW: begin
        raw  = 1'b1;
        data = w_q[7:0] ^ DpBit;
      end
      K_HEXDIG: begin
        data = hex_data(w_q[3:0], dp_q);
      end
      K_HEX16: begin
        pos     = {line_q, ~wr_q};
        wr_last = 2'd3;
      end
      K_DEC16: begin
        pos     = {line_q, ~wr_q};
        data    = hex_data(rem, 1'b0);
        wr_last = 2'd3;
      end
      K_HEX8: begin
        pos     = addr_q + AddrW'(wr_q);
        data    = hex_data(wr_q[0] ? w_q[3:0] : w_q[7:4], 1'b0);
        wr_last = 2'd1;
      end
      K_ERR: begin
        pos     = {line_q, wr_q};
        raw     = (wr_q != 2'd0);
        data    = raw ? (SegR ^ DpBit) : hex_data(DigitE, 1'b0);
        wr_last = 2'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    wr_d    = wr_q;
    w_d     = w_q;
    unique case (state_q)
      S_IDLE: begin
        wr_d = 2'd0;
        w_d  = value_i;
        if (start_i && load) begin
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        state_d = S_DATA;
      end
      S_DATA: begin
        if (wr_q == wr_last) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_CMD;
          wr_d    = wr_q + 2'd1;
          if (kind_q == K_HEX16) begin
            w_d = w_q >> 4;
          end else if (kind_q == K_DEC16) begin
            w_d = ValueW'(quot);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wr_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (state_q == S_IDLE) begin
      kind_q <= kind_d;
      addr_q <= addr_i;
      line_q <= line_i;
      dp_q   <= dp_on_i;
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign strobe_o     = (state_q == S_CMD) || (state_q == S_DATA);
  assign is_command_o = (state_q == S_CMD);
  assign last_o       = (state_q == S_DATA) && (wr_q == wr_last);
  assign port_byte_o  = is_command_o ? ({5'b00000, pos} | (raw ? CmdRaw : CmdHex)) : data;

`ifndef NO_ASSERTIONS
  a_cmd_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && is_command_o |=> strobe_o && !is_command_o)
    else $error("command byte not followed by data byte");

  a_last_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o && !is_command_o)
    else $error("last marked on a non-data result");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy_o && !strobe_o)
    else $error("results continue after last");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o)
    else $error("result strobe while idle");
`endif

endmodule

`default_nettype wire
